>>> sv/wrp_pkg.sv
// Shared types, constants and codes for the weight ring prefetch director.
package wrp_pkg;

   localparam int MAX_ENTRIES = 32;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int ADDR_W      = 48;
   localparam int SIZE_W      = 40;
   localparam int LEN_W       = 41;
   localparam int PAGE_W      = 17;
   localparam int SUM_W       = SIZE_W + CNT_W;
   localparam int CSR_W       = 40;

   localparam logic [SIZE_W-1:0] BUDGET_RESET = 40'd4294967296;
   localparam logic [SIZE_W-1:0] MIN_RESET    = 40'd1048576;
   localparam logic [PAGE_W-1:0] PAGE_RESET   = 17'd4096;

   localparam logic HINT_PREFETCH = 1'b0;
   localparam logic HINT_EVICT    = 1'b1;

   typedef enum logic [1:0] {
      CSR_BUDGET     = 2'd0,
      CSR_MIN_REGION = 2'd1,
      CSR_PAGE       = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [ADDR_W-1:0] region_address;
      logic [SIZE_W-1:0] region_size;
      logic              eligible;
   } req_item_type;

   typedef struct packed {
      logic              hint_kind;
      logic [ADDR_W-1:0] hint_start;
      logic [LEN_W-1:0]  hint_length;
      logic              last_hint;
   } rsp_item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_NEW,
      ST_FWD_INIT,
      ST_FWD_CHK,
      ST_FWD_ACC,
      ST_BWD_INIT,
      ST_BWD_CHK,
      ST_BWD_ACC,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic search_init;
      logic search_next;
      logic take_found;
      logic append;
      logic fwd_init;
      logic fwd_step;
      logic bwd_init;
      logic bwd_step;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic item_ok;
      logic table_empty;
      logic hit;
      logic search_end;
      logic fixed;
      logic full;
      logic fwd_done;
      logic over_half;
      logic bwd_done;
   } status_type;

endpackage

>>> sv/wrp_ctrl.sv
// Sequencer for search, append and the forward and backward walks.
module wrp_ctrl
   import wrp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!status.item_ok) state_in = ST_IDLE;
            else if (status.table_empty) state_in = ST_NEW;
            else state_in = ST_SRCH_RD;
         end
         ST_SRCH_RD: state_in = ST_SRCH_CMP;
         ST_SRCH_CMP: begin
            if (status.hit) state_in = ST_FWD_INIT;
            else if (status.search_end) state_in = ST_NEW;
            else state_in = ST_SRCH_RD;
         end
         ST_NEW: begin
            if (status.fixed || status.full) state_in = ST_IDLE;
            else state_in = ST_FWD_INIT;
         end
         ST_FWD_INIT: state_in = ST_FWD_CHK;
         ST_FWD_CHK: begin
            if (!status.fwd_done) state_in = ST_FWD_ACC;
            else if (status.fixed) state_in = ST_BWD_INIT;
            else state_in = ST_FINISH;
         end
         ST_FWD_ACC: begin
            if (!status.over_half) state_in = ST_FWD_CHK;
            else if (status.fixed) state_in = ST_BWD_INIT;
            else state_in = ST_FINISH;
         end
         ST_BWD_INIT: state_in = ST_BWD_CHK;
         ST_BWD_CHK: begin
            if (status.bwd_done) state_in = ST_FINISH;
            else state_in = ST_BWD_ACC;
         end
         ST_BWD_ACC: state_in = ST_BWD_CHK;
         ST_FINISH: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE:     cmd.load = start;
         ST_CHECK:    cmd.search_init = 1'b1;
         ST_SRCH_CMP: begin
            cmd.take_found  = status.hit;
            cmd.search_next = !status.hit;
         end
         ST_NEW:      cmd.append = !(status.fixed || status.full);
         ST_FWD_INIT: cmd.fwd_init = 1'b1;
         ST_FWD_ACC:  cmd.fwd_step = 1'b1;
         ST_BWD_INIT: cmd.bwd_init = 1'b1;
         ST_BWD_ACC:  cmd.bwd_step = 1'b1;
         ST_FINISH:   cmd.flush = 1'b1;
         default:     cmd = '0;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

>>> sv/wrp_dpath.sv
// Region table, walk counters, byte sums and hint output registers.
module wrp_dpath
   import wrp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  req_item_type        req_item,
   input  logic                csr_write_en,
   input  logic [1:0]          csr_index,
   input  logic [CSR_W-1:0]    csr_wdata,
   input  cmd_type             cmd,
   output status_type          status,
   output logic                rsp_valid,
   output rsp_item_type        rsp_item
);

   logic [ADDR_W-1:0] mem_addr [MAX_ENTRIES];
   logic [SIZE_W-1:0] mem_size [MAX_ENTRIES];

   logic [SIZE_W-1:0] budget_ff, min_ff;
   logic [PAGE_W-1:0] page_ff;
   req_item_type      item_ff;
   logic [ADDR_W-1:0] rd_addr_ff;
   logic [SIZE_W-1:0] rd_size_ff;
   logic [IDX_W-1:0]  idx_ff, idx_in, pos_ff, pos_in, last_pos_ff, last_pos_in;
   logic [CNT_W-1:0]  k_ff, k_in, count_ff, count_in;
   logic              fixed_ff, fixed_in;
   logic [SUM_W-1:0]  sum_ff, sum_in, sum_acc;
   rsp_item_type      pend_ff, pend_in, rsp_ff, rsp_in;
   logic              pend_valid_ff, pend_valid_in, rsp_valid_ff, rsp_valid_in;

   logic [IDX_W-1:0]  idx_fwd, pos_fwd, idx_bwd;
   logic              over, nonempty, new_hint;
   logic [PAGE_W-1:0] page_eff;
   logic [ADDR_W-1:0] start_al;
   logic [ADDR_W:0]   stop;

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= BUDGET_RESET;
         min_ff    <= MIN_RESET;
         page_ff   <= PAGE_RESET;
      end else if (csr_write_en) begin
         if (csr_index == CSR_BUDGET) budget_ff <= csr_wdata[SIZE_W-1:0];
         if (csr_index == CSR_MIN_REGION) min_ff <= csr_wdata[SIZE_W-1:0];
         if (csr_index == CSR_PAGE) page_ff <= csr_wdata[PAGE_W-1:0];
      end
   end

   // Table memory with a registered read at the walk index.
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         mem_addr[count_ff[IDX_W-1:0]] <= item_ff.region_address;
         mem_size[count_ff[IDX_W-1:0]] <= item_ff.region_size;
      end
      rd_addr_ff <= mem_addr[idx_ff];
      rd_size_ff <= mem_size[idx_ff];
   end

   assign idx_fwd = ((CNT_W'(idx_ff) + 1'b1) == count_ff) ? '0 : idx_ff + 1'b1;
   assign pos_fwd = ((CNT_W'(pos_ff) + 1'b1) == count_ff) ? '0 : pos_ff + 1'b1;
   assign idx_bwd = (idx_ff == '0) ? IDX_W'(count_ff - 1'b1) : idx_ff - 1'b1;

   assign sum_acc  = sum_ff + SUM_W'(rd_size_ff);
   assign over     = sum_acc > SUM_W'(budget_ff >> 1);
   assign page_eff = (page_ff == '0) ? PAGE_W'(1) : page_ff;
   assign start_al = rd_addr_ff & ~ADDR_W'(page_eff - 1'b1);
   assign stop     = {1'b0, rd_addr_ff} + (ADDR_W + 1)'(rd_size_ff);
   assign nonempty = stop > {1'b0, start_al};
   assign new_hint = nonempty && ((cmd.fwd_step && !over) || (cmd.bwd_step && over));

   always_comb begin
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      last_pos_in   = last_pos_ff;
      k_in          = k_ff;
      count_in      = count_ff;
      fixed_in      = fixed_ff;
      sum_in        = sum_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_in        = pend_ff;
      rsp_valid_in  = 1'b0;

      if (cmd.search_init) idx_in = '0;
      if (cmd.search_next) idx_in = idx_ff + 1'b1;
      if (cmd.take_found) begin
         pos_in      = idx_ff;
         last_pos_in = idx_ff;
         // Meeting the first entry right after the newest one closes the ring.
         if (!fixed_ff && idx_ff == '0 && (CNT_W'(last_pos_ff) + 1'b1) >= count_ff)
            fixed_in = 1'b1;
      end
      if (cmd.append) begin
         pos_in      = count_ff[IDX_W-1:0];
         last_pos_in = count_ff[IDX_W-1:0];
         count_in    = count_ff + 1'b1;
      end
      if (cmd.fwd_init) begin
         idx_in = pos_fwd;
         k_in   = CNT_W'(1);
         sum_in = '0;
      end
      if (cmd.fwd_step) begin
         sum_in = sum_acc;
         idx_in = idx_fwd;
         k_in   = k_ff + 1'b1;
      end
      if (cmd.bwd_init) begin
         idx_in = pos_ff;
         k_in   = '0;
         sum_in = '0;
      end
      if (cmd.bwd_step) begin
         sum_in = sum_acc;
         idx_in = idx_bwd;
         k_in   = k_ff + 1'b1;
      end
      // One hint is held back so the final beat of an item can carry last_hint.
      if (new_hint) begin
         rsp_valid_in           = pend_valid_ff;
         rsp_in.last_hint       = 1'b0;
         pend_valid_in          = 1'b1;
         pend_in.hint_kind      = cmd.bwd_step ? HINT_EVICT : HINT_PREFETCH;
         pend_in.hint_start     = start_al;
         pend_in.hint_length    = LEN_W'(stop - {1'b0, start_al});
         pend_in.last_hint      = 1'b0;
      end
      if (cmd.flush) begin
         rsp_valid_in     = pend_valid_ff;
         rsp_in.last_hint = 1'b1;
         pend_valid_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         fixed_ff      <= 1'b0;
         last_pos_ff   <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         fixed_ff      <= fixed_in;
         last_pos_ff   <= last_pos_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) item_ff <= req_item;
      idx_ff  <= idx_in;
      pos_ff  <= pos_in;
      k_ff    <= k_in;
      sum_ff  <= sum_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign status.item_ok     = item_ff.eligible && (item_ff.region_size >= min_ff);
   assign status.table_empty = (count_ff == '0);
   assign status.hit         = (rd_addr_ff == item_ff.region_address);
   assign status.search_end  = (CNT_W'(idx_ff) + 1'b1) >= count_ff;
   assign status.fixed       = fixed_ff;
   assign status.full        = (count_ff == CNT_W'(MAX_ENTRIES));
   assign status.fwd_done    = (k_ff >= count_ff) ||
      (!fixed_ff && ((CNT_W + 1)'(pos_ff) + (CNT_W + 1)'(k_ff)) >= (CNT_W + 1)'(count_ff));
   assign status.over_half   = over;
   assign status.bwd_done    = (k_ff >= count_ff);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES)) else $error("table count past capacity");
   a_fixed_sticky: assert property (@(posedge clock) disable iff (reset)
      fixed_ff |=> fixed_ff) else $error("ring order came loose");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      count_ff != $past(count_ff) |-> count_ff == $past(count_ff) + 1'b1)
      else $error("table count moved by more than one");
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.last_hint |-> !pend_valid_ff)
      else $error("hint still held after the final beat");

endmodule

>>> sv/weight_ring_prefetch_director.sv
// Weight ring prefetch director. An item is taken at a rising edge with start high and busy
// low, and busy stays high until the item is done. An ignored item keeps busy high for 1 cycle.
// Otherwise the block compares table entries one at a time in the address search, appends a
// new address when none matches and the ring is neither full nor fixed, and visits entries in
// the forward walk and, once the ring is fixed, in the backward walk. Each entry is read before
// it is compared or summed, as the region table has a single read port. Hints come out one per
// strobe cycle on rsp_valid and the receiver cannot stall them; the beat with last_hint set
// ends the item and comes in the first cycle after busy falls.
module weight_ring_prefetch_director
   import wrp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_item_type     req_item,
   output logic             rsp_valid,
   output rsp_item_type     rsp_item,
   input  logic             csr_write_en,
   input  logic [1:0]       csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   wrp_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   wrp_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .req_item     (req_item),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_item     (rsp_item)
   );

endmodule
